// ===== rtl/kumc_pkg.sv =====
// Package for the keypad unlock and menu cursor core.
// Holds the shared constants, action codes, register indexes and queue types.
// Has no dependencies.
package kumc_pkg;

  localparam int unsigned ScanWidth     = 32;
  localparam int unsigned KeyWidth      = 5;
  localparam int unsigned CountWidth    = 8;
  localparam int unsigned HlWidth       = 4;
  localparam int unsigned CfgIdxWidth   = 4;
  localparam int unsigned CfgDataWidth  = 8;
  localparam int unsigned QueueDepth    = 4;

  localparam int unsigned DefRows       = 8;
  localparam int unsigned DefColumns    = 4;
  localparam int unsigned DefWindowRows = 4;

  localparam logic [KeyWidth-1:0] SeqA = 5'd6;
  localparam logic [KeyWidth-1:0] SeqB = 5'd15;
  localparam logic [KeyWidth-1:0] SeqC = 5'd14;
  localparam logic [KeyWidth-1:0] SeqD = 5'd7;
  localparam logic [KeyWidth-1:0] SeqE = 5'd8;

  localparam logic [KeyWidth-1:0] KeyExit  = 5'd0;
  localparam logic [KeyWidth-1:0] KeyCodec = 5'd1;

  localparam logic [CfgIdxWidth-1:0] CfgItemCount = 4'd0;
  localparam logic [CfgIdxWidth-1:0] CfgKeyUp     = 4'd1;
  localparam logic [CfgIdxWidth-1:0] CfgKeyDown   = 4'd2;
  localparam logic [CfgIdxWidth-1:0] CfgKeySelect = 4'd3;

  localparam logic [CountWidth-1:0] ItemCountReset = 8'd8;
  localparam logic [KeyWidth-1:0]   KeyUpReset     = 5'd0;
  localparam logic [KeyWidth-1:0]   KeyDownReset   = 5'd1;
  localparam logic [KeyWidth-1:0]   KeySelectReset = 5'd2;

  typedef enum logic [3:0] {
    ActNone   = 4'd0,
    ActExit   = 4'd1,
    ActCodec  = 4'd2,
    ActOne    = 4'd3,
    ActAll    = 4'd4,
    ActEnter  = 4'd5,
    ActUp     = 4'd6,
    ActDown   = 4'd7,
    ActLaunch = 4'd8
  } action_e;

  typedef struct packed {
    logic [KeyWidth-1:0] key;
    logic                last;
  } key_entry_t;

  typedef struct packed {
    logic [CountWidth-1:0] item_count;
    logic [KeyWidth-1:0]   key_up;
    logic [KeyWidth-1:0]   key_down;
    logic [KeyWidth-1:0]   key_select;
  } cfg_t;

endpackage

// ===== rtl/kumc_front.sv =====
// Front end: takes a scan, finds newly pressed keys and issues them in ascending order.
// Depends on kumc_pkg.
module kumc_front #(
  parameter int unsigned ROWS    = kumc_pkg::DefRows,
  parameter int unsigned COLUMNS = kumc_pkg::DefColumns
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [kumc_pkg::ScanWidth-1:0]      scan_bits_i,
  input  logic                                full_i,
  output logic                                push_o,
  output kumc_pkg::key_entry_t                push_entry_o
);

  localparam int unsigned KeyTotal =
    (ROWS * COLUMNS > kumc_pkg::ScanWidth) ? kumc_pkg::ScanWidth : ROWS * COLUMNS;
  localparam logic [kumc_pkg::ScanWidth:0] MaskWide =
    ({{kumc_pkg::ScanWidth{1'b0}}, 1'b1} << KeyTotal) - 1;
  localparam logic [kumc_pkg::ScanWidth-1:0] ScanMask = MaskWide[kumc_pkg::ScanWidth-1:0];

  logic [kumc_pkg::ScanWidth-1:0] held_q, held_d;
  logic [kumc_pkg::ScanWidth-1:0] pending_q, pending_d;
  logic [kumc_pkg::ScanWidth-1:0] scan_masked;
  logic [kumc_pkg::ScanWidth-1:0] low_bit;
  logic [kumc_pkg::ScanWidth-1:0] rest;
  logic [kumc_pkg::KeyWidth-1:0]  low_idx;
  logic                           accept;

  assign in_ready_o  = (pending_q == '0);
  assign accept      = in_valid_i && in_ready_o;
  assign scan_masked = scan_bits_i & ScanMask;
  assign low_bit     = pending_q & (~pending_q + 1'b1);
  assign rest        = pending_q & ~low_bit;
  assign push_o      = !in_ready_o && !full_i;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < kumc_pkg::ScanWidth; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | kumc_pkg::KeyWidth'(i);
      end
    end
  end

  assign push_entry_o.key  = low_idx;
  assign push_entry_o.last = (rest == '0);

  always_comb begin
    held_d    = held_q;
    pending_d = pending_q;
    if (accept) begin
      held_d    = scan_masked;
      pending_d = scan_masked & ~held_q;
    end else if (push_o) begin
      pending_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      pending_q <= '0;
    end else begin
      held_q    <= held_d;
      pending_q <= pending_d;
    end
  end

endmodule

// ===== rtl/kumc_queue.sv =====
// Short request queue between the front end and the back end.
// Depends on kumc_pkg.
module kumc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  kumc_pkg::key_entry_t entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output kumc_pkg::key_entry_t entry_o
);

  localparam int unsigned PtrWidth = $clog2(kumc_pkg::QueueDepth);

  kumc_pkg::key_entry_t mem_q [kumc_pkg::QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrWidth:0]   count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == (PtrWidth+1)'(kumc_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(kumc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(kumc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/kumc_back.sv =====
// Back end: runs the unlock sequence, select mode and menu cursor for each key request.
// Depends on kumc_pkg; drives the registered result outputs.
module kumc_back #(
  parameter int unsigned WINDOW_ROWS = kumc_pkg::DefWindowRows
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  kumc_pkg::cfg_t                     cfg_i,
  input  logic                               q_valid_i,
  input  kumc_pkg::key_entry_t               q_entry_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [kumc_pkg::KeyWidth-1:0]      key_index_o,
  output logic [3:0]                         action_o,
  output logic [kumc_pkg::CountWidth-1:0]    image_index_o,
  output logic [kumc_pkg::CountWidth-1:0]    cursor_o,
  output logic [kumc_pkg::HlWidth-1:0]       highlight_row_o,
  output logic [kumc_pkg::CountWidth-1:0]    window_top_o,
  output logic                               last_o
);

  localparam logic [kumc_pkg::HlWidth:0] HlMax = (kumc_pkg::HlWidth+1)'(WINDOW_ROWS - 1);

  logic [2:0]                      step_q, step_d;
  logic                            select_q, select_d;
  logic [kumc_pkg::CountWidth-1:0] cursor_q, cursor_d;
  logic [kumc_pkg::HlWidth-1:0]    hl_q, hl_d;
  logic [kumc_pkg::CountWidth-1:0] top_q, top_d;
  logic                            out_valid_q, out_valid_d;
  kumc_pkg::action_e               act;
  logic [kumc_pkg::CountWidth-1:0] image;
  logic                            done;
  logic [kumc_pkg::KeyWidth-1:0]   key;
  logic [kumc_pkg::CountWidth:0]   key_wide;
  logic [kumc_pkg::CountWidth:0]   count_plus_one;
  logic [kumc_pkg::CountWidth:0]   cursor_plus_one;

  logic [kumc_pkg::KeyWidth-1:0]   key_index_q;
  kumc_pkg::action_e               action_q;
  logic [kumc_pkg::CountWidth-1:0] image_q;
  logic                            last_q;

  assign key             = q_entry_i.key;
  assign key_wide        = {{(kumc_pkg::CountWidth+1-kumc_pkg::KeyWidth){1'b0}}, key};
  assign count_plus_one  = {1'b0, cfg_i.item_count} + 1'b1;
  assign cursor_plus_one = {1'b0, cursor_q} + 1'b1;
  assign pop_o           = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    step_d   = step_q;
    select_d = select_q;
    cursor_d = cursor_q;
    hl_d     = hl_q;
    top_d    = top_q;
    act      = kumc_pkg::ActNone;
    image    = '0;
    done     = 1'b0;
    if (select_q) begin
      if (key == kumc_pkg::KeyExit) begin
        select_d = 1'b0;
        act      = kumc_pkg::ActExit;
      end else if (key == kumc_pkg::KeyCodec) begin
        act = kumc_pkg::ActCodec;
      end else if (key_wide <= count_plus_one) begin
        act   = kumc_pkg::ActOne;
        image = key_wide[kumc_pkg::CountWidth-1:0] - 2'd2;
      end else begin
        act      = kumc_pkg::ActAll;
        step_d   = '0;
        select_d = 1'b0;
      end
    end else begin
      if (key == kumc_pkg::SeqA) begin
        step_d = (step_q == 3'd0) ? 3'd1 : 3'd0;
      end else if (key == kumc_pkg::SeqB) begin
        step_d = (step_q == 3'd1) ? 3'd2 : 3'd0;
      end else if (key == kumc_pkg::SeqC) begin
        step_d = (step_q == 3'd2) ? 3'd3 : 3'd0;
      end else if (key == kumc_pkg::SeqD) begin
        step_d = (step_q == 3'd3) ? 3'd4 : 3'd0;
      end else if (key == kumc_pkg::SeqE) begin
        done   = (step_q == 3'd4);
        step_d = 3'd0;
      end

      if (key == cfg_i.key_up) begin
        if (cursor_q != '0) begin
          cursor_d = cursor_q - 1'b1;
          if (hl_q != '0) begin
            hl_d = hl_q - 1'b1;
          end else begin
            top_d = top_q - 1'b1;
          end
        end
        act = kumc_pkg::ActUp;
      end else if (key == cfg_i.key_down) begin
        if (cursor_plus_one < {1'b0, cfg_i.item_count}) begin
          cursor_d = cursor_q + 1'b1;
          if ({1'b0, hl_q} < HlMax) begin
            hl_d = hl_q + 1'b1;
          end else begin
            top_d = top_q + 1'b1;
          end
        end
        act = kumc_pkg::ActDown;
      end else if (key == cfg_i.key_select) begin
        act = kumc_pkg::ActLaunch;
      end

      if (done) begin
        select_d = 1'b1;
        act      = kumc_pkg::ActEnter;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      select_q    <= 1'b0;
      cursor_q    <= '0;
      hl_q        <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        step_q   <= step_d;
        select_q <= select_d;
        cursor_q <= cursor_d;
        hl_q     <= hl_d;
        top_q    <= top_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      key_index_q <= key;
      action_q    <= act;
      image_q     <= image;
      last_q      <= q_entry_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign key_index_o     = key_index_q;
  assign action_o        = action_q;
  assign image_index_o   = image_q;
  assign cursor_o        = cursor_q;
  assign highlight_row_o = hl_q;
  assign window_top_o    = top_q;
  assign last_o          = last_q;

endmodule

// ===== rtl/keypad_unlock_and_menu_cursor_core.sv =====
// Keypad unlock and menu cursor core: top level with configuration registers.
// Path: a scan's new keys pass the front end's pending register, the queue and the result registers.
// Throughput: one key result per cycle unless the output or queue stalls; the front end
// takes no new scan until it has issued all new presses (up to 32) of the last one.
// Reset: asynchronous, active low; clears held keys, sequence, mode, cursor and registers.
// Depends on kumc_pkg, kumc_front, kumc_queue and kumc_back.
module keypad_unlock_and_menu_cursor_core #(
  parameter int unsigned ROWS        = kumc_pkg::DefRows,
  parameter int unsigned COLUMNS     = kumc_pkg::DefColumns,
  parameter int unsigned WINDOW_ROWS = kumc_pkg::DefWindowRows
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [kumc_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [kumc_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [kumc_pkg::ScanWidth-1:0]       scan_bits_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [kumc_pkg::KeyWidth-1:0]        key_index_o,
  output logic [3:0]                           action_o,
  output logic [kumc_pkg::CountWidth-1:0]      image_index_o,
  output logic [kumc_pkg::CountWidth-1:0]      cursor_o,
  output logic [kumc_pkg::HlWidth-1:0]         highlight_row_o,
  output logic [kumc_pkg::CountWidth-1:0]      window_top_o,
  output logic                                 last_o
);

  kumc_pkg::cfg_t       cfg_q, cfg_d;
  kumc_pkg::key_entry_t push_entry;
  kumc_pkg::key_entry_t pop_entry;
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 q_valid;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        kumc_pkg::CfgItemCount: cfg_d.item_count = cfg_data_i;
        kumc_pkg::CfgKeyUp:     cfg_d.key_up     = cfg_data_i[kumc_pkg::KeyWidth-1:0];
        kumc_pkg::CfgKeyDown:   cfg_d.key_down   = cfg_data_i[kumc_pkg::KeyWidth-1:0];
        kumc_pkg::CfgKeySelect: cfg_d.key_select = cfg_data_i[kumc_pkg::KeyWidth-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.item_count <= kumc_pkg::ItemCountReset;
      cfg_q.key_up     <= kumc_pkg::KeyUpReset;
      cfg_q.key_down   <= kumc_pkg::KeyDownReset;
      cfg_q.key_select <= kumc_pkg::KeySelectReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  kumc_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .scan_bits_i  (scan_bits_i),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  kumc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  kumc_back #(
    .WINDOW_ROWS (WINDOW_ROWS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_entry_i       (pop_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .key_index_o     (key_index_o),
    .action_o        (action_o),
    .image_index_o   (image_index_o),
    .cursor_o        (cursor_o),
    .highlight_row_o (highlight_row_o),
    .window_top_o    (window_top_o),
    .last_o          (last_o)
  );

  a_window_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cursor_o == window_top_o + {4'b0, highlight_row_o})
    else $error("Cursor does not match window top plus highlight row.");

  a_highlight_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, highlight_row_o} < (kumc_pkg::HlWidth+1)'(WINDOW_ROWS))
    else $error("Highlight row lies outside the visible window.");

  a_image_only_for_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o != kumc_pkg::ActOne) |-> image_index_o == '0)
    else $error("Image index is set for an action other than one image.");

endmodule

// ===== sim/kumc_press_checker.sv =====
`timescale 1ns / 1ps
// Checker for the keypad unlock and menu cursor core: watches the register, scan and
// result channels, predicts one result per newly pressed key and compares each result.
// Depends on kumc_pkg only.
module kumc_press_checker #(
  parameter int unsigned ROWS        = kumc_pkg::DefRows,
  parameter int unsigned COLUMNS     = kumc_pkg::DefColumns,
  parameter int unsigned WINDOW_ROWS = kumc_pkg::DefWindowRows
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [kumc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [kumc_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [kumc_pkg::ScanWidth-1:0]    scan_bits_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [kumc_pkg::KeyWidth-1:0]     key_index_i,
  input  logic [3:0]                        action_i,
  input  logic [kumc_pkg::CountWidth-1:0]   image_index_i,
  input  logic [kumc_pkg::CountWidth-1:0]   cursor_i,
  input  logic [kumc_pkg::HlWidth-1:0]      highlight_row_i,
  input  logic [kumc_pkg::CountWidth-1:0]   window_top_i,
  input  logic                              last_i,
  output int                                mismatches_o,
  output int                                waiting_o,
  output int                                scans_o,
  output int                                presses_o
);

  localparam int unsigned KeyTotal = (ROWS * COLUMNS > 32) ? 32 : ROWS * COLUMNS;

  typedef struct packed {
    logic [kumc_pkg::KeyWidth-1:0]   key;
    kumc_pkg::action_e               act;
    logic [kumc_pkg::CountWidth-1:0] image;
    logic [kumc_pkg::CountWidth-1:0] cursor;
    logic [kumc_pkg::HlWidth-1:0]    hl;
    logic [kumc_pkg::CountWidth-1:0] top;
    logic                            last;
  } press_result_t;

  press_result_t press_results_q[$];

  logic [kumc_pkg::CountWidth-1:0] item_count = kumc_pkg::ItemCountReset;
  logic [kumc_pkg::KeyWidth-1:0]   key_up     = kumc_pkg::KeyUpReset;
  logic [kumc_pkg::KeyWidth-1:0]   key_down   = kumc_pkg::KeyDownReset;
  logic [kumc_pkg::KeyWidth-1:0]   key_select = kumc_pkg::KeySelectReset;

  logic [kumc_pkg::ScanWidth-1:0]  held_keys   = '0;
  logic [2:0]                      unlock_step = '0;
  logic                            select_mode = 1'b0;
  logic [kumc_pkg::CountWidth-1:0] cursor_pos  = '0;
  logic [kumc_pkg::HlWidth-1:0]    hl_pos      = '0;
  logic [kumc_pkg::CountWidth-1:0] top_pos     = '0;

  task automatic report_mismatch(input string what, input longint expv, input longint gotv);
    mismatches_o++;
    $display("%0t ns: result %0d, %s: expected %0d, got %0d", $time, presses_o, what,
             expv, gotv);
  endtask

  task automatic predict_scan(input logic [kumc_pkg::ScanWidth-1:0] raw);
    logic [kumc_pkg::ScanWidth-1:0] scan;
    logic [kumc_pkg::ScanWidth-1:0] fresh;
    logic [kumc_pkg::KeyWidth-1:0]  key;
    press_result_t                  r;
    int                             remaining;
    bit                             done;
    scan = (KeyTotal >= 32) ? raw : raw & ((32'h1 << KeyTotal) - 32'h1);
    fresh = scan & ~held_keys;
    held_keys = scan;
    remaining = $countones(fresh);
    for (int k = 0; k < KeyTotal; k++) begin
      if (fresh[k]) begin
        key = k[kumc_pkg::KeyWidth-1:0];
        r = '0;
        r.key = key;
        r.act = kumc_pkg::ActNone;
        if (select_mode) begin
          if (key == kumc_pkg::KeyExit) begin
            select_mode = 1'b0;
            r.act = kumc_pkg::ActExit;
          end else if (key == kumc_pkg::KeyCodec) begin
            r.act = kumc_pkg::ActCodec;
          end else if (int'(key) <= int'(item_count) + 1) begin
            r.act = kumc_pkg::ActOne;
            r.image = {3'b000, key} - 8'd2;
          end else begin
            r.act = kumc_pkg::ActAll;
            unlock_step = '0;
            select_mode = 1'b0;
          end
        end else begin
          done = 1'b0;
          case (key)
            kumc_pkg::SeqA: unlock_step = (unlock_step == 3'd0) ? 3'd1 : 3'd0;
            kumc_pkg::SeqB: unlock_step = (unlock_step == 3'd1) ? 3'd2 : 3'd0;
            kumc_pkg::SeqC: unlock_step = (unlock_step == 3'd2) ? 3'd3 : 3'd0;
            kumc_pkg::SeqD: unlock_step = (unlock_step == 3'd3) ? 3'd4 : 3'd0;
            kumc_pkg::SeqE: begin
              done = (unlock_step == 3'd4);
              unlock_step = 3'd0;
            end
            default: ;
          endcase
          if (done) select_mode = 1'b1;
          if (key == key_up) begin
            if (cursor_pos > 0) begin
              cursor_pos = cursor_pos - 8'd1;
              if (hl_pos > 0) hl_pos = hl_pos - 4'd1;
              else top_pos = top_pos - 8'd1;
            end
            r.act = kumc_pkg::ActUp;
          end else if (key == key_down) begin
            if (int'(cursor_pos) < int'(item_count) - 1) begin
              cursor_pos = cursor_pos + 8'd1;
              if (int'(hl_pos) < int'(WINDOW_ROWS) - 1) hl_pos = hl_pos + 4'd1;
              else top_pos = top_pos + 8'd1;
            end
            r.act = kumc_pkg::ActDown;
          end else if (key == key_select) begin
            r.act = kumc_pkg::ActLaunch;
          end
          if (done) r.act = kumc_pkg::ActEnter;
        end
        remaining--;
        r.cursor = cursor_pos;
        r.hl = hl_pos;
        r.top = top_pos;
        r.last = (remaining == 0);
        press_results_q.push_back(r);
      end
    end
  endtask

  task automatic check_press();
    press_result_t want;
    presses_o++;
    if (press_results_q.size() == 0) begin
      report_mismatch("result with no press waiting, key", -1, key_index_i);
    end else begin
      want = press_results_q.pop_front();
      if (key_index_i !== want.key) report_mismatch("key_index", want.key, key_index_i);
      if (action_i !== want.act) report_mismatch("action", want.act, action_i);
      if (image_index_i !== want.image) report_mismatch("image_index", want.image, image_index_i);
      if (cursor_i !== want.cursor) report_mismatch("cursor", want.cursor, cursor_i);
      if (highlight_row_i !== want.hl) report_mismatch("highlight_row", want.hl, highlight_row_i);
      if (window_top_i !== want.top) report_mismatch("window_top", want.top, window_top_i);
      if (last_i !== want.last) report_mismatch("last", want.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count = kumc_pkg::ItemCountReset;
      key_up = kumc_pkg::KeyUpReset;
      key_down = kumc_pkg::KeyDownReset;
      key_select = kumc_pkg::KeySelectReset;
      held_keys = '0;
      unlock_step = '0;
      select_mode = 1'b0;
      cursor_pos = '0;
      hl_pos = '0;
      top_pos = '0;
      press_results_q.delete();
      waiting_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_press();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          kumc_pkg::CfgItemCount: item_count = cfg_data_i;
          kumc_pkg::CfgKeyUp:     key_up = cfg_data_i[kumc_pkg::KeyWidth-1:0];
          kumc_pkg::CfgKeyDown:   key_down = cfg_data_i[kumc_pkg::KeyWidth-1:0];
          kumc_pkg::CfgKeySelect: key_select = cfg_data_i[kumc_pkg::KeyWidth-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        scans_o++;
        predict_scan(scan_bits_i);
      end
      waiting_o = press_results_q.size();
    end
  end

endmodule

// ===== sim/keypad_unlock_and_menu_cursor_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for keypad_unlock_and_menu_cursor_core: drives key scans and register
// writes, stalls the result side at random, and gives the verdict.
// Depends on kumc_pkg, the core RTL and kumc_press_checker.
module keypad_unlock_and_menu_cursor_core_tb;

  localparam int CycleLimit   = 400000;
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 10;
  localparam int PhaseItems   = 33;
  localparam logic [kumc_pkg::CfgIdxWidth-1:0] CfgSpare = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [kumc_pkg::CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [kumc_pkg::CfgDataWidth-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [kumc_pkg::ScanWidth-1:0] scan_bits_i = '0;
  logic out_ready_i = 1'b0;

  logic cfg_ready_o;
  logic in_ready_o;
  logic out_valid_o;
  logic [kumc_pkg::KeyWidth-1:0] key_index_o;
  logic [3:0] action_o;
  logic [kumc_pkg::CountWidth-1:0] image_index_o;
  logic [kumc_pkg::CountWidth-1:0] cursor_o;
  logic [kumc_pkg::HlWidth-1:0] highlight_row_o;
  logic [kumc_pkg::CountWidth-1:0] window_top_o;
  logic last_o;

  int mismatches;
  int waiting;
  int scans_seen;
  int presses_seen;
  int cycle_count = 0;
  int sent = 0;
  int settings_used = 0;

  logic [kumc_pkg::ScanWidth-1:0]  last_scan = '0;
  logic [kumc_pkg::CountWidth-1:0] items_cfg = kumc_pkg::ItemCountReset;
  logic [kumc_pkg::KeyWidth-1:0]   up_cfg = kumc_pkg::KeyUpReset;
  logic [kumc_pkg::KeyWidth-1:0]   down_cfg = kumc_pkg::KeyDownReset;
  logic [kumc_pkg::KeyWidth-1:0]   sel_cfg = kumc_pkg::KeySelectReset;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  keypad_unlock_and_menu_cursor_core uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .scan_bits_i, .out_valid_o, .out_ready_i,
    .key_index_o, .action_o, .image_index_o, .cursor_o, .highlight_row_o,
    .window_top_o, .last_o
  );

  kumc_press_checker press_check (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .scan_bits_i,
    .out_valid_i(out_valid_o), .out_ready_i, .key_index_i(key_index_o),
    .action_i(action_o), .image_index_i(image_index_o), .cursor_i(cursor_o),
    .highlight_row_i(highlight_row_o), .window_top_i(window_top_o), .last_i(last_o),
    .mismatches_o(mismatches), .waiting_o(waiting), .scans_o(scans_seen),
    .presses_o(presses_seen)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, waiting);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_scan(input logic [kumc_pkg::ScanWidth-1:0] bits);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    scan_bits_i <= bits;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    last_scan = bits;
    sent++;
  endtask

  task automatic tap(input logic [kumc_pkg::KeyWidth-1:0] k);
    logic [kumc_pkg::ScanWidth-1:0] bit_k;
    bit_k = 32'h1 << k;
    if ((last_scan & bit_k) != '0) send_scan(last_scan & ~bit_k);
    send_scan(bit_k | (last_scan & $urandom() & ~bit_k));
  endtask

  task automatic enter_code(input int steps);
    for (int i = 0; i < steps; i++) begin
      case (i)
        0: tap(kumc_pkg::SeqA);
        1: tap(kumc_pkg::SeqB);
        2: tap(kumc_pkg::SeqC);
        3: tap(kumc_pkg::SeqD);
        default: tap(kumc_pkg::SeqE);
      endcase
    end
  endtask

  task automatic write_reg(input logic [kumc_pkg::CfgIdxWidth-1:0] idx,
                           input logic [kumc_pkg::CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apply_setting(input int p);
    logic [kumc_pkg::CountWidth-1:0] cnt;
    logic [kumc_pkg::KeyWidth-1:0] u, d, s;
    case (p)
      0: begin cnt = 8'd1;   u = 5'd3;  d = 5'd4;  s = 5'd5;  end
      1: begin cnt = 8'd255; u = 5'd31; d = 5'd30; s = 5'd29; end
      2: begin
        cnt = 8'd0;
        u = kumc_pkg::SeqA;
        d = kumc_pkg::SeqB;
        s = kumc_pkg::SeqE;
      end
      3: begin cnt = 8'd6;   u = 5'd9;  d = 5'd9;  s = 5'd9;  end
      4: begin cnt = 8'd3;   u = 5'd0;  d = 5'd31; s = 5'd14; end
      default: begin
        cnt = 8'($urandom_range(1, 255));
        u = 5'($urandom());
        d = 5'($urandom());
        s = 5'($urandom());
        write_reg(CfgSpare, 8'($urandom()));
      end
    endcase
    write_reg(kumc_pkg::CfgItemCount, cnt);
    write_reg(kumc_pkg::CfgKeyUp, {3'($urandom()), u});
    write_reg(kumc_pkg::CfgKeyDown, {3'($urandom()), d});
    write_reg(kumc_pkg::CfgKeySelect, {3'($urandom()), s});
    cfg_valid_i <= 1'b0;
    items_cfg = cnt;
    up_cfg = u;
    down_cfg = d;
    sel_cfg = s;
    settings_used++;
  endtask

  task automatic run_episode();
    int kind;
    int top_key;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      enter_code(5);
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0: tap(kumc_pkg::KeyExit);
          1: tap(kumc_pkg::KeyCodec);
          2, 3, 4, 5: begin
            top_key = (int'(items_cfg) + 1 > 31) ? 31 : int'(items_cfg) + 1;
            tap(5'($urandom_range(2, top_key)));
          end
          6, 7, 8: tap(5'($urandom_range(0, 31)));
          default: send_scan($urandom());
        endcase
      end
    end else if (kind <= 4) begin
      repeat ($urandom_range(3, 12)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: tap(down_cfg);
          5, 6, 7: tap(up_cfg);
          8: tap(sel_cfg);
          default: tap(5'($urandom_range(0, 31)));
        endcase
      end
    end else if (kind == 5) begin
      enter_code($urandom_range(1, 4));
      tap(5'($urandom_range(0, 31)));
      enter_code(5);
    end else if (kind == 6) begin
      send_scan($urandom());
    end else if (kind == 7) begin
      send_scan($urandom() & $urandom());
    end else if (kind == 8) begin
      send_scan('0);
      tap(5'($urandom_range(0, 31)));
    end else begin
      send_scan(last_scan ^ (32'h1 << $urandom_range(0, 31)));
    end
  endtask

  initial begin : receiver
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        out_ready_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
      end
    end
  end

  initial begin : stimulus
    int target;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with the reset register values.
    send_scan('0);
    send_scan(32'hFFFF_FFFF);
    send_scan(32'hFFFF_FFFF);
    send_scan('0);
    enter_code(5);
    send_scan(32'h1 << kumc_pkg::KeyCodec);
    send_scan(32'h1 << 2);
    send_scan(32'h1 << 9);
    send_scan(32'h1 << 10);
    tap(kumc_pkg::SeqA);
    tap(5'd20);
    tap(kumc_pkg::SeqB);
    tap(kumc_pkg::SeqC);
    tap(kumc_pkg::SeqD);
    tap(kumc_pkg::SeqE);
    tap(kumc_pkg::KeyExit);
    tap(kumc_pkg::KeyDownReset);
    tap(kumc_pkg::KeyUpReset);
    tap(kumc_pkg::KeySelectReset);
    send_scan(32'h8000_0000);

    for (int p = 0; p < 6; p++) begin
      settle();
      apply_setting(p);
      calm = (p == 3);
      if (p == 1) begin
        hold_req = 1'b1;
        repeat (12) send_scan($urandom());
      end
      target = sent + PhaseItems;
      while (sent < target) run_episode();
    end
    settle();

    $display("Run covered %0d scans and %0d key results under %0d register settings,",
             scans_seen, presses_seen, settings_used + 1);
    $display("including item counts of 0, 1 and 255, shared keys and a long output stall.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
